/* sv/dbvd_pkg.sv */
// dbvd_pkg: shared constants, types and the chroma table of the block video decoder
// no dependencies; imported by every module of the decoder except dbvd_ram
package dbvd_pkg;

    localparam int MAX_BLOCKS_ACROSS = 80;
    localparam int MAX_BLOCKS_DOWN   = 64;
    localparam int BANK_DEPTH        = MAX_BLOCKS_ACROSS * MAX_BLOCKS_DOWN;
    localparam int ADDR_W            = $clog2(BANK_DEPTH);
    localparam int PIX_W             = 15;
    localparam int LUMA_W            = 5;
    localparam int CFG_W             = 7;
    localparam int COL_W             = 7;
    localparam int ROW_W             = 6;
    localparam int ACC_W             = 64;
    localparam int HELD_W            = 7;
    localparam int POS_W             = 5;
    localparam int SKIP_W            = 16;
    localparam int DCNT_W            = $clog2(SKIP_W + 1);
    localparam int RUN_W             = 3;
    localparam int MAX_RUN           = 4;

    localparam logic [31:0] ID_PLAIN    = 32'h0000_0100;
    localparam logic [31:0] ID_RESERVED = 32'h0000_0102;
    localparam logic [PIX_W-1:0] CHROMA_MASK = 15'h7fe0;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_RESERVED = 2'd1,
        PH_DECODE   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        FS_DECODING = 2'd0,
        FS_DONE     = 2'd1,
        FS_BAD_ID   = 2'd2,
        FS_TRUNC    = 2'd3
    } fstatus_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_LOOP,
        S_DIV,
        S_RD,
        S_DEC,
        S_STAT,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic     accept;
        logic     start_frame;
        logic     to_decode;
        logic     append;
        logic     skip_apply;
        logic     div_step;
        logic     div_finish;
        logic     commit;
        logic     set_code;
        fstatus_t code;
        logic     push_status;
        logic     flush;
        logic     clear_step;
    } cmd_t;

    typedef struct packed {
        logic   fs;
        logic   fe;
        logic   id_ok;
        logic   active;
        phase_t phase;
        logic   n_full;
        logic   pending;
        logic   skip_ok;
        logic   block_ok;
        logic   div_done;
        logic   frame_over;
        logic   can_push;
        logic   hold_valid;
        logic   out_free;
        logic   clear_last;
    } sts_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] tl;
        logic [PIX_W-1:0] tr;
        logic [PIX_W-1:0] bl;
        logic [PIX_W-1:0] br;
        logic             written;
        fstatus_t         status;
        logic             last;
    } res_t;

    localparam logic [15:0] CHROMA_ROM [256] = '{
        16'h77a0, 16'h77c0, 16'h77e0, 16'h7400, 16'h7420, 16'h7440, 16'h7460, 16'h7ba0,
        16'h7bc0, 16'h7be0, 16'h7800, 16'h7820, 16'h7840, 16'h7860, 16'h7fa0, 16'h7fc0,
        16'h7fe0, 16'h7c00, 16'h7c20, 16'h7c40, 16'h7c60, 16'h03a0, 16'h03c0, 16'h03e0,
        16'h0000, 16'h0020, 16'h0040, 16'h0060, 16'h07a0, 16'h07c0, 16'h07e0, 16'h0400,
        16'h0420, 16'h0440, 16'h0460, 16'h0ba0, 16'h0bc0, 16'h0be0, 16'h0800, 16'h0820,
        16'h0840, 16'h0860, 16'h0fa0, 16'h0fc0, 16'h0fe0, 16'h0c00, 16'h0c20, 16'h0c40,
        16'h0c60, 16'h3340, 16'h30c0, 16'h2400, 16'h1a80, 16'h1800, 16'h1980, 16'h0cc0,
        16'h02e0, 16'h0180, 16'h74c0, 16'h6ae0, 16'h6860, 16'h5ee0, 16'h5c60, 16'h53a0,
        16'h77a0, 16'h77c0, 16'h77e0, 16'h7400, 16'h7420, 16'h7440, 16'h7460, 16'h7ba0,
        16'h7bc0, 16'h7be0, 16'h7800, 16'h7820, 16'h7840, 16'h7860, 16'h7fa0, 16'h7fc0,
        16'h7fe0, 16'h7c00, 16'h7c20, 16'h7c40, 16'h7c60, 16'h03a0, 16'h03c0, 16'h03e0,
        16'h0000, 16'h0020, 16'h0040, 16'h0060, 16'h07a0, 16'h07c0, 16'h07e0, 16'h0400,
        16'h0420, 16'h0440, 16'h0460, 16'h0ba0, 16'h0bc0, 16'h0be0, 16'h0800, 16'h0820,
        16'h0840, 16'h0860, 16'h0fa0, 16'h0fc0, 16'h0fe0, 16'h0c00, 16'h0c20, 16'h0c40,
        16'h0c60, 16'h33a0, 16'h26e0, 16'h2460, 16'h1ae0, 16'h1860, 16'h0e80, 16'h0d20,
        16'h0340, 16'h7680, 16'h7520, 16'h6b40, 16'h68c0, 16'h5f40, 16'h5cc0, 16'h5000,
        16'h77a0, 16'h77c0, 16'h77e0, 16'h7400, 16'h7420, 16'h7440, 16'h7460, 16'h7ba0,
        16'h7bc0, 16'h7be0, 16'h7800, 16'h7820, 16'h7840, 16'h7860, 16'h7fa0, 16'h7fc0,
        16'h7fe0, 16'h7c00, 16'h7c20, 16'h7c40, 16'h7c60, 16'h03a0, 16'h03c0, 16'h03e0,
        16'h0000, 16'h0020, 16'h0040, 16'h0060, 16'h07a0, 16'h07c0, 16'h07e0, 16'h0400,
        16'h0420, 16'h0440, 16'h0460, 16'h0ba0, 16'h0bc0, 16'h0be0, 16'h0800, 16'h0820,
        16'h0840, 16'h0860, 16'h0fa0, 16'h0fc0, 16'h0fe0, 16'h0c00, 16'h0c20, 16'h0c40,
        16'h0c60, 16'h3000, 16'h2740, 16'h24c0, 16'h1b40, 16'h18c0, 16'h0ee0, 16'h0d80,
        16'h00c0, 16'h76e0, 16'h7580, 16'h6ba0, 16'h6920, 16'h5fa0, 16'h5d20, 16'h5060,
        16'h77a0, 16'h77c0, 16'h77e0, 16'h7400, 16'h7420, 16'h7440, 16'h7460, 16'h7ba0,
        16'h7bc0, 16'h7be0, 16'h7800, 16'h7820, 16'h7840, 16'h7860, 16'h7fa0, 16'h7fc0,
        16'h7fe0, 16'h7c00, 16'h7c20, 16'h7c40, 16'h7c60, 16'h03a0, 16'h03c0, 16'h03e0,
        16'h0000, 16'h0020, 16'h0040, 16'h0060, 16'h07a0, 16'h07c0, 16'h07e0, 16'h0400,
        16'h0420, 16'h0440, 16'h0460, 16'h0ba0, 16'h0bc0, 16'h0be0, 16'h0800, 16'h0820,
        16'h0840, 16'h0860, 16'h0fa0, 16'h0fc0, 16'h0fe0, 16'h0c00, 16'h0c20, 16'h0c40,
        16'h0c60, 16'h33a0, 16'h27a0, 16'h2520, 16'h1ba0, 16'h1920, 16'h0f40, 16'h0280,
        16'h0120, 16'h7740, 16'h6a80, 16'h6800, 16'h6980, 16'h5c00, 16'h5340, 16'h50c0
    };

endpackage

/* sv/dbvd_ram.sv */
// dbvd_ram: generic single-clock ram, one write and one registered read port
// no dependencies
module dbvd_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 5120
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/dbvd_ctrl.sv */
// dbvd_ctrl: sequencing state machine of the block video decoder
// depends on dbvd_pkg; drives the datapath through cmd_t, watches sts_t
module dbvd_ctrl import dbvd_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next-state logic; at the end of a word's payload: truncation report or straight to flush
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (sts.fs)
                begin
                    if (!sts.id_ok || sts.fe)
                    begin
                        state_next = S_STAT;
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
                else if (!sts.active || sts.phase == PH_IDLE)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.phase == PH_RESERVED)
                begin
                    state_next = sts.fe ? S_STAT : S_FLUSH;
                end
                else
                begin
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                if (sts.n_full || (!sts.pending && !sts.skip_ok))
                begin
                    state_next = sts.fe ? S_STAT : S_FLUSH;
                end
                else if (!sts.pending)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = sts.frame_over ? S_STAT : S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (!sts.block_ok)
                begin
                    state_next = sts.fe ? S_STAT : S_FLUSH;
                end
                else if (sts.can_push)
                begin
                    state_next = S_LOOP;
                end
            end
            S_STAT:
            begin
                if (sts.can_push)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!sts.hold_valid || sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.code = FS_DECODING;
        in_stall = (state_reg != S_IDLE);
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            S_IDLE:
            begin
                cmd.accept = in_valid;
            end
            S_HEAD:
            begin
                if (sts.fs)
                begin
                    cmd.start_frame = 1'b1;
                    if (!sts.id_ok)
                    begin
                        cmd.set_code = 1'b1;
                        cmd.code     = FS_BAD_ID;
                    end
                    else if (sts.fe)
                    begin
                        cmd.set_code = 1'b1;
                        cmd.code     = FS_TRUNC;
                    end
                end
                else if (sts.active && sts.phase == PH_RESERVED)
                begin
                    cmd.to_decode = 1'b1;
                    cmd.set_code  = sts.fe;
                    cmd.code      = FS_TRUNC;
                end
                else if (sts.active && sts.phase == PH_DECODE)
                begin
                    cmd.append = 1'b1;
                end
            end
            S_LOOP:
            begin
                if (sts.n_full || (!sts.pending && !sts.skip_ok))
                begin
                    cmd.set_code = sts.fe;
                    cmd.code     = FS_TRUNC;
                end
                else if (!sts.pending)
                begin
                    cmd.skip_apply = 1'b1;
                end
            end
            S_DIV:
            begin
                if (!sts.div_done)
                begin
                    cmd.div_step = 1'b1;
                end
                else if (sts.frame_over)
                begin
                    cmd.set_code = 1'b1;
                    cmd.code     = FS_DONE;
                end
                else
                begin
                    cmd.div_finish = 1'b1;
                end
            end
            S_DEC:
            begin
                if (!sts.block_ok)
                begin
                    cmd.set_code = sts.fe;
                    cmd.code     = FS_TRUNC;
                end
                else if (sts.can_push)
                begin
                    cmd.commit = 1'b1;
                end
            end
            S_STAT:
            begin
                cmd.push_status = sts.can_push;
            end
            S_FLUSH:
            begin
                cmd.flush = sts.hold_valid && sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* sv/dbvd_datapath.sv */
// dbvd_datapath: bit accumulator, field decode, cursor divider, picture banks, result registers
// depends on dbvd_pkg and dbvd_ram; controlled by dbvd_ctrl
module dbvd_datapath import dbvd_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic [31:0]      data_word,
    input  logic             frame_start,
    input  logic             frame_end,
    input  logic             out_stall,
    input  cmd_t             cmd,
    output sts_t             sts,
    output logic             out_valid,
    output res_t             out_res
);

    logic [CFG_W-1:0]  across_reg;
    logic [CFG_W-1:0]  down_reg;
    logic [31:0]       word_reg;
    logic              fs_reg;
    logic              fe_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [HELD_W-1:0] held_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    phase_t            phase_reg;
    logic              active_reg;
    logic              pending_reg;
    logic [RUN_W-1:0]  n_reg;
    fstatus_t          code_reg;
    logic [SKIP_W-1:0] dvd_reg;
    logic [COL_W-1:0]  rem_reg;
    logic [SKIP_W-1:0] quo_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [ADDR_W-1:0] clr_reg;
    res_t              out_reg;
    logic              out_valid_reg;
    res_t              hold_reg;
    logic              hold_valid_reg;

    logic [COL_W-1:0]  bw;
    logic [CFG_W-1:0]  bh;
    logic              out_free;
    logic              can_push;

    // geometry clamp: zero acts as one, large values saturate
    always_comb
    begin
        if (across_reg == '0)
        begin
            bw = COL_W'(1);
        end
        else if (across_reg > CFG_W'(MAX_BLOCKS_ACROSS))
        begin
            bw = COL_W'(MAX_BLOCKS_ACROSS);
        end
        else
        begin
            bw = across_reg;
        end
        if (down_reg == '0)
        begin
            bh = CFG_W'(1);
        end
        else if (down_reg > CFG_W'(MAX_BLOCKS_DOWN))
        begin
            bh = CFG_W'(MAX_BLOCKS_DOWN);
        end
        else
        begin
            bh = down_reg;
        end
    end

    // skip run decode
    logic              skip_ok;
    logic [POS_W-1:0]  skip_len;
    logic [SKIP_W-1:0] skip_val;

    always_comb
    begin
        skip_ok  = 1'b0;
        skip_len = '0;
        skip_val = '0;
        if (held_reg >= HELD_W'(1))
        begin
            if (!acc_reg[0])
            begin
                skip_ok  = 1'b1;
                skip_len = POS_W'(1);
            end
            else if (held_reg >= HELD_W'(4))
            begin
                if (acc_reg[3:1] != 3'b111)
                begin
                    skip_ok  = 1'b1;
                    skip_len = POS_W'(4);
                    skip_val = SKIP_W'(1) + SKIP_W'(acc_reg[3:1]);
                end
                else if (held_reg >= HELD_W'(11))
                begin
                    if (acc_reg[10:4] != 7'h7f)
                    begin
                        skip_ok  = 1'b1;
                        skip_len = POS_W'(11);
                        skip_val = SKIP_W'(8) + SKIP_W'(acc_reg[10:4]);
                    end
                    else if (held_reg >= HELD_W'(26))
                    begin
                        skip_ok  = 1'b1;
                        skip_len = POS_W'(26);
                        skip_val = SKIP_W'(135) + SKIP_W'(acc_reg[25:11]);
                    end
                end
            end
        end
    end

    // block decode
    logic              blk_ok;
    logic [POS_W-1:0]  blk_len;
    logic              keep;
    logic              need_idx;
    logic              hdr;
    logic [5:0]        i6;
    logic [7:0]        idx;
    logic [2:0]        sel;
    logic [LUMA_W-1:0] la;
    logic [LUMA_W-1:0] lb;

    always_comb
    begin
        blk_ok   = 1'b0;
        blk_len  = '0;
        keep     = 1'b0;
        need_idx = 1'b0;
        hdr      = 1'b0;
        i6       = '0;
        idx      = '0;
        sel      = acc_reg[3:1];
        la       = acc_reg[8:4];
        lb       = acc_reg[13:9];
        if (held_reg >= HELD_W'(1))
        begin
            if (acc_reg[0])
            begin
                if (held_reg >= HELD_W'(9))
                begin
                    blk_len = POS_W'(9);
                    hdr     = 1'b1;
                    if (sel != 3'b000)
                    begin
                        if (held_reg >= HELD_W'(14))
                        begin
                            blk_len = POS_W'(14);
                        end
                        else
                        begin
                            hdr = 1'b0;
                        end
                    end
                    if (hdr && held_reg >= HELD_W'(blk_len) + HELD_W'(1))
                    begin
                        need_idx = acc_reg[blk_len];
                        keep     = !acc_reg[blk_len];
                        blk_ok   = !acc_reg[blk_len];
                        blk_len  = blk_len + POS_W'(1);
                    end
                end
            end
            else
            begin
                blk_len  = POS_W'(1);
                need_idx = 1'b1;
            end
        end
        if (need_idx && held_reg >= HELD_W'(blk_len) + HELD_W'(6))
        begin
            i6      = acc_reg[blk_len +: 6];
            blk_len = blk_len + POS_W'(6);
            if (i6 > 6'd48)
            begin
                if (held_reg >= HELD_W'(blk_len) + HELD_W'(2))
                begin
                    idx     = {acc_reg[blk_len +: 2], i6};
                    blk_len = blk_len + POS_W'(2);
                    blk_ok  = 1'b1;
                end
            end
            else
            begin
                idx    = {2'b00, i6};
                blk_ok = 1'b1;
            end
        end
    end

    // picture banks, one per pixel position of a block
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] waddr;
    logic              we;
    logic [PIX_W-1:0]  rd [4];
    logic [PIX_W-1:0]  px [4];
    logic [PIX_W-1:0]  wd [4];
    logic [PIX_W-1:0]  chroma;

    assign cur_addr = ADDR_W'(32'(row_reg) * MAX_BLOCKS_ACROSS + 32'(col_reg));
    assign chroma   = keep ? (rd[0] & CHROMA_MASK) : CHROMA_ROM[idx][PIX_W-1:0];

    always_comb
    begin
        if (acc_reg[0])
        begin
            px[0] = {chroma[PIX_W-1:LUMA_W], la};
            px[1] = {chroma[PIX_W-1:LUMA_W], sel[0] ? lb : la};
            px[2] = {chroma[PIX_W-1:LUMA_W], sel[1] ? lb : la};
            px[3] = {chroma[PIX_W-1:LUMA_W], sel[2] ? lb : la};
        end
        else
        begin
            px[0] = {chroma[PIX_W-1:LUMA_W], rd[0][LUMA_W-1:0]};
            px[1] = {chroma[PIX_W-1:LUMA_W], rd[1][LUMA_W-1:0]};
            px[2] = {chroma[PIX_W-1:LUMA_W], rd[2][LUMA_W-1:0]};
            px[3] = {chroma[PIX_W-1:LUMA_W], rd[3][LUMA_W-1:0]};
        end
    end

    assign we    = cmd.clear_step || cmd.commit;
    assign waddr = cmd.clear_step ? clr_reg : cur_addr;

    for (genvar k = 0; k < 4; k++)
    begin : g_bank
        assign wd[k] = cmd.clear_step ? '0 : px[k];
        dbvd_ram #(
            .WIDTH (PIX_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (we),
            .waddr (waddr),
            .wdata (wd[k]),
            .raddr (cur_addr),
            .rdata (rd[k])
        );
    end

    // cursor divider: one quotient bit a cycle
    logic [COL_W:0]    dtrial;
    logic              dbit;
    logic [SKIP_W:0]   row_new;

    assign dtrial  = {rem_reg, dvd_reg[SKIP_W-1]};
    assign dbit    = dtrial >= {1'b0, bw};
    assign row_new = (SKIP_W + 1)'(row_reg) + (SKIP_W + 1)'(quo_reg);

    // result staging: the newest result waits in hold until its successor or the flush
    res_t new_res;

    always_comb
    begin
        new_res = '0;
        if (cmd.commit)
        begin
            new_res.col     = col_reg;
            new_res.row     = row_reg;
            new_res.tl      = px[0];
            new_res.tr      = px[1];
            new_res.bl      = px[2];
            new_res.br      = px[3];
            new_res.written = 1'b1;
            new_res.status  = FS_DECODING;
        end
        else
        begin
            new_res.status = code_reg;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign can_push = !hold_valid_reg || out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            word_reg <= data_word;
            fs_reg   <= frame_start;
            fe_reg   <= frame_end;
        end
        if (cmd.set_code)
        begin
            code_reg <= cmd.code;
        end
        if (cmd.skip_apply)
        begin
            dvd_reg  <= SKIP_W'(col_reg) + skip_val;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[SKIP_W-2:0], 1'b0};
            rem_reg <= dbit ? COL_W'(dtrial - {1'b0, bw}) : dtrial[COL_W-1:0];
            quo_reg <= {quo_reg[SKIP_W-2:0], dbit};
        end
        if (cmd.commit || cmd.push_status)
        begin
            hold_reg <= new_res;
            if (hold_valid_reg)
            begin
                out_reg      <= hold_reg;
                out_reg.last <= 1'b0;
            end
        end
        else if (cmd.flush && hold_valid_reg)
        begin
            out_reg      <= hold_reg;
            out_reg.last <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            across_reg     <= CFG_W'(MAX_BLOCKS_ACROSS);
            down_reg       <= CFG_W'(MAX_BLOCKS_DOWN);
            acc_reg        <= '0;
            held_reg       <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            phase_reg      <= PH_IDLE;
            active_reg     <= 1'b0;
            pending_reg    <= 1'b0;
            n_reg          <= '0;
            dcnt_reg       <= '0;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index)
                begin
                    down_reg <= cfg_data;
                end
                else
                begin
                    across_reg <= cfg_data;
                end
            end
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (cmd.start_frame)
            begin
                acc_reg     <= '0;
                held_reg    <= '0;
                col_reg     <= '0;
                row_reg     <= '0;
                pending_reg <= 1'b0;
                if (word_reg == ID_PLAIN)
                begin
                    phase_reg  <= PH_DECODE;
                    active_reg <= 1'b1;
                end
                else if (word_reg == ID_RESERVED)
                begin
                    phase_reg  <= PH_RESERVED;
                    active_reg <= 1'b1;
                end
                else
                begin
                    phase_reg  <= PH_IDLE;
                    active_reg <= 1'b0;
                end
            end
            else if (cmd.to_decode)
            begin
                phase_reg <= PH_DECODE;
            end
            else if (cmd.append)
            begin
                acc_reg  <= acc_reg | ({32'b0, word_reg} << held_reg[5:0]);
                held_reg <= held_reg + HELD_W'(32);
                n_reg    <= '0;
            end
            else if (cmd.skip_apply)
            begin
                acc_reg  <= acc_reg >> skip_len;
                held_reg <= held_reg - HELD_W'(skip_len);
                dcnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg + DCNT_W'(1);
            end
            else if (cmd.div_finish)
            begin
                col_reg     <= rem_reg;
                row_reg     <= row_new[ROW_W-1:0];
                pending_reg <= 1'b1;
            end
            else if (cmd.commit)
            begin
                acc_reg     <= acc_reg >> blk_len;
                held_reg    <= held_reg - HELD_W'(blk_len);
                col_reg     <= col_reg + COL_W'(1);
                pending_reg <= 1'b0;
                n_reg       <= n_reg + RUN_W'(1);
            end
            else if (cmd.push_status)
            begin
                // frame closes on every status transaction
                acc_reg     <= '0;
                held_reg    <= '0;
                col_reg     <= '0;
                row_reg     <= '0;
                pending_reg <= 1'b0;
                phase_reg   <= PH_IDLE;
                active_reg  <= 1'b0;
            end

            if (cmd.commit || cmd.push_status)
            begin
                hold_valid_reg <= 1'b1;
                out_valid_reg  <= hold_valid_reg || (out_valid_reg && out_stall);
            end
            else if (cmd.flush && hold_valid_reg)
            begin
                hold_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
            else
            begin
                out_valid_reg <= out_valid_reg && out_stall;
            end
        end
    end

    assign sts.fs         = fs_reg;
    assign sts.fe         = fe_reg;
    assign sts.id_ok      = (word_reg == ID_PLAIN) || (word_reg == ID_RESERVED);
    assign sts.active     = active_reg;
    assign sts.phase      = phase_reg;
    assign sts.n_full     = (n_reg == RUN_W'(MAX_RUN));
    assign sts.pending    = pending_reg;
    assign sts.skip_ok    = skip_ok;
    assign sts.block_ok   = blk_ok;
    assign sts.div_done   = (dcnt_reg == DCNT_W'(SKIP_W));
    assign sts.frame_over = row_new >= (SKIP_W + 1)'(bh);
    assign sts.can_push   = can_push;
    assign sts.hold_valid = hold_valid_reg;
    assign sts.out_free   = out_free;
    assign sts.clear_last = (clr_reg == ADDR_W'(BANK_DEPTH - 1));

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

`ifndef SYNTHESIS
    a_commit_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> pending_reg && blk_ok)
        else $error("block committed without an applied skip run");
    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= RUN_W'(MAX_RUN))
        else $error("more than four blocks from one word");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit || cmd.push_status) |-> can_push)
        else $error("result pushed with no room in the output register");
    a_cursor_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_finish |=> (CFG_W'(row_reg) < bh) && (col_reg < bw))
        else $error("cursor left the picture after a skip run");
`endif

endmodule

/* sv/delta_block_video_decoder.sv */
// delta_block_video_decoder: top level of the delta-coded 2x2 block video decoder
// depends on dbvd_pkg, dbvd_ctrl, dbvd_datapath (which holds four dbvd_ram banks)
//
//   channel  direction  handshake              payload
//   input    in         in_valid / in_stall    data_word, frame_start, frame_end
//   output   out        out_valid / out_stall  block_col .. last_of_run
//   config   in         cfg_we                 cfg_index, cfg_data
//
// a payload word is decoded block by block; each block takes a skip run, the cursor divider
// after the skip run, one bank read and one write
// after reset every address of the picture banks is cleared, with in_stall held high
// in_stall is low only between transactions; out_stall holds decoding once the output
// register and the one-result hold stage are both full
module delta_block_video_decoder import dbvd_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [31:0]      data_word,
    input  logic             frame_start,
    input  logic             frame_end,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [COL_W-1:0] block_col,
    output logic [ROW_W-1:0] block_row,
    output logic [PIX_W-1:0] pixel_top_left,
    output logic [PIX_W-1:0] pixel_top_right,
    output logic [PIX_W-1:0] pixel_bottom_left,
    output logic [PIX_W-1:0] pixel_bottom_right,
    output logic             block_written,
    output logic [1:0]       frame_status,
    output logic             last_of_run
);

    cmd_t cmd;
    sts_t sts;
    res_t res;

    dbvd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    dbvd_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .data_word   (data_word),
        .frame_start (frame_start),
        .frame_end   (frame_end),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_res     (res)
    );

    assign block_col          = res.col;
    assign block_row          = res.row;
    assign pixel_top_left     = res.tl;
    assign pixel_top_right    = res.tr;
    assign pixel_bottom_left  = res.bl;
    assign pixel_bottom_right = res.br;
    assign block_written      = res.written;
    assign frame_status       = res.status;
    assign last_of_run        = res.last;

endmodule
